// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while rst_n is low
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while rst_n is low
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/obmct_pkg.sv =====
// ----------------------------------------------------------------------------
// obmct_pkg
// shared types and constants of the bipartite colour tracker
// ----------------------------------------------------------------------------
package obmct_pkg;

    localparam int NODE_W          = 10;
    localparam int TOTAL_W         = 10;
    localparam int MAX_NODES_DEF   = 1024;
    localparam int S_TDATA_W       = 24;
    localparam int M_TDATA_W       = 16;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_X,
        ST_RD_Y,
        ST_WALK,
        ST_LINK_RD,
        ST_LINK_WR,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/obmct_ram.sv =====
// ----------------------------------------------------------------------------
// obmct_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module obmct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/online_bipartite_min_color_tracker.sv =====
// ----------------------------------------------------------------------------
// online_bipartite_min_color_tracker
// union-find two-colouring with small-to-large merging over two rams
// ----------------------------------------------------------------------------
// Each input word carries one edge; each edge gives exactly one output word
// with the running sum of min(coloured, uncoloured) over all components and
// a sticky odd-cycle flag; once the flag is set the sum reads as zero. The
// block clears all entries of its node and component rams after reset
// before it takes the first word. An edge inside one component, or any edge
// once the flag is set, reads both nodes and then gives its word. A merge
// reads both component words, walks the node ram's member list of the smaller
// component, then links the lists and writes the merged component word. An
// edge with an index at or above MAX_NODES changes nothing. Before each
// output word the block waits while the one before is not yet taken.
module online_bipartite_min_color_tracker #(
    parameter int MAX_NODES = obmct_pkg::MAX_NODES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [obmct_pkg::S_TDATA_W-1:0] s_tdata,  // node_a, node_b, zero pad
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [obmct_pkg::M_TDATA_W-1:0] m_tdata,  // min_colored_total, zero pad
    output logic                           m_tuser    // conflict
);

    localparam int NW  = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int SW  = $clog2(MAX_NODES + 1);
    localparam int NDW = 2 * NW + 1;
    localparam int CDW = 2 * NW + 2 * SW;
    localparam int TW  = obmct_pkg::TOTAL_W;

    obmct_pkg::state_t state_reg, state_next;

    logic [NW-1:0]  clr_reg, clr_next;
    logic [NW-1:0]  b_reg, b_next;
    logic [NW-1:0]  a_reg, a_next;
    logic [NW-1:0]  x_reg, x_next;
    logic [NW-1:0]  y_reg, y_next;
    logic           ca_reg, ca_next;
    logic           flip_reg, flip_next;
    logic           odd_reg, odd_next;
    logic [CDW-1:0] cx_reg, cx_next;
    logic [NW-1:0]  small_reg, small_next;
    logic [NW-1:0]  large_reg, large_next;
    logic [SW-1:0]  szs_reg, szs_next;
    logic [SW-1:0]  szl_reg, szl_next;
    logic [SW-1:0]  coll_reg, coll_next;
    logic [NW-1:0]  heads_reg, heads_next;
    logic [NW-1:0]  tails_reg, tails_next;
    logic [NW-1:0]  headl_reg, headl_next;
    logic [NW-1:0]  taill_reg, taill_next;
    logic [NW-1:0]  cur_reg, cur_next;
    logic [SW-1:0]  cnt_reg, cnt_next;
    logic [SW-1:0]  acc_reg, acc_next;
    logic [SW-1:0]  oldsum_reg, oldsum_next;
    logic [SW-1:0]  total_reg, total_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic [TW-1:0]  m_total_reg, m_total_next;
    logic           m_conf_reg, m_conf_next;

    logic           n_we, c_we;
    logic [NW-1:0]  n_waddr, n_raddr, c_waddr, c_raddr;
    logic [NDW-1:0] n_wdata, n_rdata;
    logic [CDW-1:0] c_wdata, c_rdata;

    obmct_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
        .aclk(aclk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
        .raddr(n_raddr), .rdata(n_rdata)
    );

    obmct_ram #(.WIDTH(CDW), .DEPTH(MAX_NODES)) u_comp_ram (
        .aclk(aclk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
        .raddr(c_raddr), .rdata(c_rdata)
    );

    // node word: comp, colour, next ; comp word: size, coloured, head, tail
    logic [NW-1:0] nr_next, nr_comp;
    logic          nr_color;
    logic [SW-1:0] cy_size, cy_col, cxs, cxc, minx, miny;
    logic [NW-1:0] cy_head, cy_tail, cx_head, cx_tail;
    logic [9:0]    in_a, in_b;
    logic          in_ok, newc;
    logic [SW-1:0] msz, mcol, mmin;
    logic [31:0]   tot32;

    assign nr_next  = n_rdata[NW-1:0];
    assign nr_color = n_rdata[NW];
    assign nr_comp  = n_rdata[2*NW:NW+1];
    assign cy_tail  = c_rdata[NW-1:0];
    assign cy_head  = c_rdata[2*NW-1:NW];
    assign cy_col   = c_rdata[2*NW+SW-1:2*NW];
    assign cy_size  = c_rdata[CDW-1:2*NW+SW];
    assign cx_tail  = cx_reg[NW-1:0];
    assign cx_head  = cx_reg[2*NW-1:NW];
    assign cxc      = cx_reg[2*NW+SW-1:2*NW];
    assign cxs      = cx_reg[CDW-1:2*NW+SW];
    assign minx     = (cxc < (cxs - cxc)) ? cxc : (cxs - cxc);
    assign miny     = (cy_col < (cy_size - cy_col)) ? cy_col : (cy_size - cy_col);
    assign in_a     = s_tdata[9:0];
    assign in_b     = s_tdata[19:10];
    assign in_ok    = (32'(in_a) < 32'(MAX_NODES)) && (32'(in_b) < 32'(MAX_NODES));
    assign newc     = nr_color ^ flip_reg;
    assign msz      = szl_reg + szs_reg;
    assign mcol     = coll_reg + acc_reg;
    assign mmin     = (mcol < (msz - mcol)) ? mcol : (msz - mcol);
    assign tot32    = 32'(total_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= obmct_pkg::ST_CLEAR;
            clr_reg      <= '0;
            odd_reg      <= 1'b0;
            total_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            odd_reg      <= odd_next;
            total_reg    <= total_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        a_reg      <= a_next;
        b_reg      <= b_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        ca_reg     <= ca_next;
        flip_reg   <= flip_next;
        cx_reg     <= cx_next;
        small_reg  <= small_next;
        large_reg  <= large_next;
        szs_reg    <= szs_next;
        szl_reg    <= szl_next;
        coll_reg   <= coll_next;
        heads_reg  <= heads_next;
        tails_reg  <= tails_next;
        headl_reg  <= headl_next;
        taill_reg  <= taill_next;
        cur_reg    <= cur_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        oldsum_reg <= oldsum_next;
        m_total_reg <= m_total_next;
        m_conf_reg  <= m_conf_next;
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        ca_next       = ca_reg;
        flip_next     = flip_reg;
        odd_next      = odd_reg;
        cx_next       = cx_reg;
        small_next    = small_reg;
        large_next    = large_reg;
        szs_next      = szs_reg;
        szl_next      = szl_reg;
        coll_next     = coll_reg;
        heads_next    = heads_reg;
        tails_next    = tails_reg;
        headl_next    = headl_reg;
        taill_next    = taill_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        oldsum_next   = oldsum_reg;
        total_next    = total_reg;
        m_tvalid_next = m_tvalid_reg;
        m_total_next  = m_total_reg;
        m_conf_next   = m_conf_reg;
        s_tready      = 1'b0;
        n_we          = 1'b0;
        n_waddr       = cur_reg;
        n_wdata       = '0;
        n_raddr       = a_reg;
        c_we          = 1'b0;
        c_waddr       = small_reg;
        c_wdata       = '0;
        c_raddr       = x_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            obmct_pkg::ST_CLEAR: begin
                n_we    = 1'b1;
                n_waddr = clr_reg;
                n_wdata = {clr_reg, 1'b0, clr_reg};
                c_we    = 1'b1;
                c_waddr = clr_reg;
                c_wdata = {SW'(1), SW'(0), clr_reg, clr_reg};
                clr_next = clr_reg + NW'(1);
                if (32'(clr_reg) == 32'(MAX_NODES - 1)) begin
                    state_next = obmct_pkg::ST_IDLE;
                end
            end
            obmct_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                n_raddr  = NW'(in_a);
                a_next   = NW'(in_a);
                b_next   = NW'(in_b);
                if (s_tvalid) begin
                    state_next = in_ok ? obmct_pkg::ST_RD_A : obmct_pkg::ST_DONE;
                end
            end
            obmct_pkg::ST_RD_A: begin
                x_next     = nr_comp;
                ca_next    = nr_color;
                n_raddr    = b_reg;
                state_next = obmct_pkg::ST_RD_B;
            end
            obmct_pkg::ST_RD_B: begin
                y_next    = nr_comp;
                flip_next = (ca_reg == nr_color);
                c_raddr   = x_reg;
                if (x_reg == nr_comp) begin
                    if (ca_reg == nr_color) begin
                        odd_next = 1'b1;
                    end
                    state_next = obmct_pkg::ST_DONE;
                end else if (odd_reg) begin
                    state_next = obmct_pkg::ST_DONE;
                end else begin
                    state_next = obmct_pkg::ST_RD_X;
                end
            end
            obmct_pkg::ST_RD_X: begin
                cx_next    = c_rdata;
                c_raddr    = y_reg;
                state_next = obmct_pkg::ST_RD_Y;
            end
            obmct_pkg::ST_RD_Y: begin
                oldsum_next = minx + miny;
                acc_next    = '0;
                if (cxs <= cy_size) begin
                    small_next = x_reg;
                    large_next = y_reg;
                    szs_next   = cxs;
                    szl_next   = cy_size;
                    coll_next  = cy_col;
                    heads_next = cx_head;
                    tails_next = cx_tail;
                    headl_next = cy_head;
                    taill_next = cy_tail;
                    cnt_next   = cxs;
                    cur_next   = cx_head;
                    n_raddr    = cx_head;
                end else begin
                    small_next = y_reg;
                    large_next = x_reg;
                    szs_next   = cy_size;
                    szl_next   = cxs;
                    coll_next  = cxc;
                    heads_next = cy_head;
                    tails_next = cy_tail;
                    headl_next = cx_head;
                    taill_next = cx_tail;
                    cnt_next   = cy_size;
                    cur_next   = cy_head;
                    n_raddr    = cy_head;
                end
                state_next = obmct_pkg::ST_WALK;
            end
            obmct_pkg::ST_WALK: begin
                n_we     = 1'b1;
                n_waddr  = cur_reg;
                n_wdata  = {large_reg, newc, nr_next};
                acc_next = acc_reg + SW'(newc);
                n_raddr  = nr_next;
                cur_next = nr_next;
                cnt_next = cnt_reg - SW'(1);
                if (cnt_reg == SW'(1)) begin
                    state_next = obmct_pkg::ST_LINK_RD;
                end
            end
            obmct_pkg::ST_LINK_RD: begin
                c_we       = 1'b1;
                c_waddr    = small_reg;
                c_wdata    = {SW'(0), SW'(0), heads_reg, tails_reg};
                n_raddr    = taill_reg;
                state_next = obmct_pkg::ST_LINK_WR;
            end
            obmct_pkg::ST_LINK_WR: begin
                n_we       = 1'b1;
                n_waddr    = taill_reg;
                n_wdata    = {nr_comp, nr_color, heads_reg};
                c_we       = 1'b1;
                c_waddr    = large_reg;
                c_wdata    = {msz, mcol, headl_reg, tails_reg};
                total_next = total_reg - oldsum_reg + mmin;
                state_next = obmct_pkg::ST_DONE;
            end
            obmct_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_total_next  = odd_reg ? '0 : tot32[TW-1:0];
                    m_conf_next   = odd_reg;
                    state_next    = obmct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = obmct_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(obmct_pkg::M_TDATA_W - TW)'(0), m_total_reg};
    assign m_tuser  = m_conf_reg;

endmodule

// ===== rtl/obmct_checker.sv =====
// ----------------------------------------------------------------------------
// obmct_checker
// port-level checks of the bipartite colour tracker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module obmct_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [obmct_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                            m_tuser
);

    `CHK_NEXT(a_reset_quiet, aclk, 1'b1, !aresetn, !m_tvalid)
    `CHK_IMPL(a_conflict_zero, aclk, aresetn, m_tvalid && m_tuser, m_tdata == '0)
    `CHK_IMPL(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[15:10] == 6'd0)
    `CHK_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
              m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `CHK_NEXT(a_one_word_in_flight, aclk, aresetn, s_tvalid && s_tready, !s_tready)

endmodule

bind online_bipartite_min_color_tracker obmct_checker u_obmct_checker (
    .aclk(aclk), .aresetn(aresetn),
    .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
